@@ sv/nml_pkg.sv @@
// Shared types, constants and helpers for the neighbourhood majority label unit.
`default_nettype none
package nml_pkg;

	localparam int NEIGH_COUNT = 8;
	localparam int SLOT_BITS   = 8;
	localparam int ADJ_BITS    = 4;
	localparam int CNT_BITS    = 4;

	localparam logic [ADJ_BITS-1:0] RESET_MIN_ADJACENT = 4'd3;

	typedef logic [SLOT_BITS-1:0] label_t;
	typedef logic [CNT_BITS-1:0]  count_t;

	// One lane's finding: a label and how many qualifying neighbours carry it.
	typedef struct packed {
		count_t count;
		label_t label;
	} cand_t;

	// Higher count wins; on equal count the smaller label wins.
	function automatic cand_t pick_better(input cand_t a, input cand_t b);
		cand_t r;
		if (b.count > a.count || (b.count == a.count && b.label < a.label)) begin
			r = b;
		end else begin
			r = a;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/nml_lane.sv @@
// One vote lane: counts qualifying neighbours that carry this lane's label.
`default_nettype none
module nml_lane
	import nml_pkg::*;
(
	input  label_t                   own_label,
	input  logic                     own_ok,
	input  label_t [NEIGH_COUNT-1:0] labels,
	input  logic   [NEIGH_COUNT-1:0] oks,
	output cand_t                    cand
);

	count_t cnt;

	always_comb begin
		cnt = '0;
		for (int j = 0; j < NEIGH_COUNT; j++) begin
			cnt = cnt + {{(CNT_BITS-1){1'b0}}, (oks[j] && labels[j] == own_label)};
		end
		cand.label = own_label;
		cand.count = own_ok ? cnt : '0;
	end

endmodule
`default_nettype wire

@@ sv/nml_merge.sv @@
// Merge tree: reduces the lane findings to the winning label and its count.
`default_nettype none
module nml_merge
	import nml_pkg::*;
(
	input  cand_t [NEIGH_COUNT-1:0]   cands,
	output cand_t                     best
);

	cand_t [NEIGH_COUNT/2-1:0] lvl1;
	cand_t [NEIGH_COUNT/4-1:0] lvl2;

	always_comb begin
		for (int i = 0; i < NEIGH_COUNT/2; i++) begin
			lvl1[i] = pick_better(cands[2*i], cands[2*i+1]);
		end
		for (int i = 0; i < NEIGH_COUNT/4; i++) begin
			lvl2[i] = pick_better(lvl1[2*i], lvl1[2*i+1]);
		end
		best = pick_better(lvl2[0], lvl2[1]);
	end

endmodule
`default_nettype wire

@@ sv/neighbourhood_majority_label_unit.sv @@
// Top level of the neighbourhood majority label unit (3x3 label mode filter).
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  neighbour_labels, neighbour_adjacency,
//                                           neighbour_present, centre_label
//  out      output     out_valid/out_stall  new_label, voted, vote_count
//  cfg      input      cfg_valid/cfg_ready  cfg_data (min_adjacent)
//
// One item per cycle sustained while the output is not stalled.
// Stage 1 qualifies each neighbour, stage 2 runs eight count lanes in parallel,
// the merge tree feeds the output register.
// Each stage holds while the one after it is full and stalled; empty stages
// still take a new request. Reset empties the pipe and sets min_adjacent to 3.
// cfg_ready is always high.
`default_nettype none
module neighbourhood_majority_label_unit
	import nml_pkg::*;
#(
	parameter int LABEL_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] neighbour_labels,
	input  logic [31:0] neighbour_adjacency,
	input  logic [7:0]  neighbour_present,
	input  logic [7:0]  centre_label,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  new_label,
	output logic        voted,
	output logic [3:0]  vote_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	localparam label_t LABEL_MASK = SLOT_BITS'((1 << LABEL_BITS) - 1);

	logic [ADJ_BITS-1:0] min_adjacent_q;

	logic                     valid_s1, valid_s2, out_valid_q;
	label_t [NEIGH_COUNT-1:0] labels_s1;
	logic   [NEIGH_COUNT-1:0] ok_s1;
	label_t                   centre_s1, centre_s2;
	cand_t  [NEIGH_COUNT-1:0] cands_s2;
	cand_t  [NEIGH_COUNT-1:0] lane_cands;
	cand_t                    best;
	label_t                   new_label_q;
	logic                     voted_q;
	count_t                   vote_count_q;

	label_t [NEIGH_COUNT-1:0] in_labels;
	logic   [NEIGH_COUNT-1:0] in_ok;

	logic out_rdy, s2_rdy, s1_rdy;

	assign out_rdy   = !out_valid_q || !out_stall;
	assign s2_rdy    = !valid_s2 || out_rdy;
	assign s1_rdy    = !valid_s1 || s2_rdy;
	assign in_stall  = !s1_rdy;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_adjacent_q <= RESET_MIN_ADJACENT;
		end else if (cfg_valid && cfg_ready) begin
			min_adjacent_q <= cfg_data;
		end
	end

	// Qualify each neighbour
	always_comb begin
		for (int i = 0; i < NEIGH_COUNT; i++) begin
			in_labels[i] = neighbour_labels[SLOT_BITS*i +: SLOT_BITS] & LABEL_MASK;
			in_ok[i]     = neighbour_present[i] && (in_labels[i] != '0) &&
				(neighbour_adjacency[ADJ_BITS*i +: ADJ_BITS] >= min_adjacent_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_rdy) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_rdy && in_valid) begin
			labels_s1 <= in_labels;
			ok_s1     <= in_ok;
			centre_s1 <= centre_label & LABEL_MASK;
		end
	end

	for (genvar g = 0; g < NEIGH_COUNT; g++) begin : g_lane
		nml_lane u_lane (
			.own_label (labels_s1[g]),
			.own_ok    (ok_s1[g]),
			.labels    (labels_s1),
			.oks       (ok_s1),
			.cand      (lane_cands[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_rdy) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_rdy && valid_s1) begin
			cands_s2  <= lane_cands;
			centre_s2 <= centre_s1;
		end
	end

	nml_merge u_merge (
		.cands (cands_s2),
		.best  (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_rdy) begin
			out_valid_q <= valid_s2;
		end
	end

	// Fall back to the centre label when nobody qualified
	always_ff @(posedge clk) begin
		if (out_rdy && valid_s2) begin
			if (best.count == '0) begin
				new_label_q  <= centre_s2;
				voted_q      <= 1'b0;
				vote_count_q <= '0;
			end else begin
				new_label_q  <= best.label;
				voted_q      <= 1'b1;
				vote_count_q <= best.count;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign new_label  = new_label_q;
	assign voted      = voted_q;
	assign vote_count = vote_count_q;

endmodule
`default_nettype wire

@@ sv/nml_checker.sv @@
// Port-level checker for the neighbourhood majority label unit, with its bind.
`default_nettype none
module nml_checker #(
	parameter int LABEL_BITS = 8
) (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] new_label,
	input logic       voted,
	input logic [3:0] vote_count
);

	a_voted_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && voted |-> vote_count != 4'd0 && new_label != 8'd0)
		else $error("voted result without votes or with label zero");

	a_unvoted_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !voted |-> vote_count == 4'd0)
		else $error("vote count set on a pass-through result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> vote_count <= 4'd8 && (new_label >> LABEL_BITS) == 8'd0)
		else $error("vote count or label out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_label) && $stable(voted)
			&& $stable(vote_count))
		else $error("stalled result changed");

endmodule

bind neighbourhood_majority_label_unit nml_checker #(.LABEL_BITS(LABEL_BITS)) u_nml_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.new_label  (new_label),
	.voted      (voted),
	.vote_count (vote_count)
);
`default_nettype wire
